// ----- hw/rtl/lrcdf_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrcdf_pkg
// Shared types and constants of the STX/ETX LRC field deframer.
// ---------------------------------------------------------------------------
package lrcdf_pkg;

  localparam int unsigned DATA_W  = 56;  // width of one result's field data
  localparam int unsigned IDX_W   = 3;   // field index width
  localparam int unsigned LEN_W   = 3;   // field length width
  localparam int unsigned STAT_W  = 3;   // status width
  localparam int unsigned COUNT_W = 4;   // field count, holds up to eight

  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] SEP_BYTE = 8'h7C;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_IDLE_TO   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_STX   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BODY_TO   = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd4;
  localparam logic [STAT_W-1:0] ST_LRC_TO    = 3'd5;
  localparam logic [STAT_W-1:0] ST_LRC_BAD   = 3'd6;

  typedef enum logic {
    CMD_ERROR,
    CMD_BURST
  } cmd_kind_t;

  // One unit of work from the front end to the result sequencer.
  typedef struct packed {
    cmd_kind_t            kind;
    logic [STAT_W-1:0]    status;
    logic [COUNT_W-1:0]   count;
  } cmd_t;

  // Field store read response.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } field_rd_t;

endpackage

// ----- hw/rtl/lrcdf_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrcdf_in_if / lrcdf_out_if
// Valid/ready channels for received bytes and for deframed results.
// ---------------------------------------------------------------------------
interface lrcdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timeout;

  modport source (output valid, output rx_byte, output timeout, input ready);
  modport sink   (input valid, input rx_byte, input timeout, output ready);
endinterface

interface lrcdf_out_if;
  logic                              valid;
  logic                              ready;
  logic [lrcdf_pkg::STAT_W-1:0]      status;
  logic [lrcdf_pkg::IDX_W-1:0]       field_index;
  logic [lrcdf_pkg::LEN_W-1:0]       field_length;
  logic [lrcdf_pkg::DATA_W-1:0]      field_data;
  logic                              is_last;

  modport source (output valid, output status, output field_index, output field_length,
                  output field_data, output is_last, input ready);
  modport sink   (input valid, input status, input field_index, input field_length,
                  input field_data, input is_last, output ready);
endinterface

// ----- hw/rtl/lrcdf_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrcdf_front
// Frame parser: tracks STX/body/LRC phases, splits fields into the field
// store and issues error or burst commands to the queue.
// ---------------------------------------------------------------------------
module lrcdf_front #(
  parameter int unsigned MAX_FIELDS       = 8,
  parameter int unsigned FIELD_SLOT_BYTES = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  lrcdf_in_if.sink                     din,
  input  logic                         q_ready,
  output logic                         push,
  output lrcdf_pkg::cmd_t              push_cmd,
  input  logic                         burst_done,
  input  logic [lrcdf_pkg::IDX_W-1:0]  rd_idx,
  output lrcdf_pkg::field_rd_t         rd
);

  localparam int unsigned KEEP_BYTES = FIELD_SLOT_BYTES - 1;
  localparam int unsigned KEEP_W     = 8 * KEEP_BYTES;
  localparam int unsigned RAW_LIMIT  = MAX_FIELDS * FIELD_SLOT_BYTES + 2;
  localparam int unsigned RAW_W      = $clog2(RAW_LIMIT + 1);
  localparam int unsigned SIDX_W     = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BODY,
    PH_CHECK
  } phase_t;

  phase_t                                phase;
  logic                                  hold;
  logic [7:0]                            lrc;
  logic [RAW_W-1:0]                      raw_count;
  logic [lrcdf_pkg::COUNT_W-1:0]         fields_kept;
  logic [lrcdf_pkg::LEN_W-1:0]           cur_chars;
  logic [KEEP_W-1:0]                     cur_data;
  logic [KEEP_W-1:0]                     cur_data_next;

  logic [KEEP_W-1:0]                     store_data [MAX_FIELDS];
  logic [lrcdf_pkg::LEN_W-1:0]           store_len  [MAX_FIELDS];

  logic       acc;
  logic [7:0] b;
  logic       to;
  logic       body_byte;
  logic       is_split;
  logic       room;
  logic       do_close;
  logic       do_add;

  assign din.ready = !hold && q_ready;
  assign acc       = din.valid && din.ready;
  assign b         = din.rx_byte;
  assign to        = din.timeout;

  assign body_byte = acc && (phase == PH_BODY) && !to &&
                     (raw_count < RAW_W'(RAW_LIMIT));
  assign is_split  = (b == lrcdf_pkg::ETX_BYTE) || (b == lrcdf_pkg::SEP_BYTE);
  assign room      = fields_kept < lrcdf_pkg::COUNT_W'(MAX_FIELDS);
  assign do_close  = body_byte && is_split;
  assign do_add    = body_byte && !is_split && room &&
                     (cur_chars < lrcdf_pkg::LEN_W'(KEEP_BYTES));

  always_comb begin
    cur_data_next = cur_data;
    for (int i = 0; i < KEEP_BYTES; i++) begin
      if (cur_chars == lrcdf_pkg::LEN_W'(i)) begin
        cur_data_next[8*i +: 8] = b;
      end
    end
  end

  // Command generation for the accepted byte.
  always_comb begin
    push     = 1'b0;
    push_cmd = '0;
    if (acc) begin
      case (phase)
        PH_IDLE: begin
          if (to) begin
            push            = 1'b1;
            push_cmd.status = lrcdf_pkg::ST_IDLE_TO;
          end else if (b != lrcdf_pkg::STX_BYTE) begin
            push            = 1'b1;
            push_cmd.status = lrcdf_pkg::ST_NOT_STX;
          end
        end
        PH_BODY: begin
          if (to) begin
            push            = 1'b1;
            push_cmd.status = lrcdf_pkg::ST_BODY_TO;
          end else if (raw_count >= RAW_W'(RAW_LIMIT)) begin
            push            = 1'b1;
            push_cmd.status = lrcdf_pkg::ST_TOO_LONG;
          end
        end
        PH_CHECK: begin
          push = 1'b1;
          if (to) begin
            push_cmd.status = lrcdf_pkg::ST_LRC_TO;
          end else if (b != lrc) begin
            push_cmd.status = lrcdf_pkg::ST_LRC_BAD;
          end else begin
            push_cmd.kind   = lrcdf_pkg::CMD_BURST;
            push_cmd.status = lrcdf_pkg::ST_OK;
            push_cmd.count  = fields_kept;
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      hold        <= 1'b0;
      lrc         <= '0;
      raw_count   <= '0;
      fields_kept <= '0;
      cur_chars   <= '0;
      cur_data    <= '0;
    end else begin
      if (burst_done) begin
        hold <= 1'b0;
      end
      if (acc) begin
        case (phase)
          PH_IDLE: begin
            if (!to && b == lrcdf_pkg::STX_BYTE) begin
              phase       <= PH_BODY;
              lrc         <= '0;
              raw_count   <= '0;
              fields_kept <= '0;
              cur_chars   <= '0;
              cur_data    <= '0;
            end
          end
          PH_BODY: begin
            if (!body_byte) begin
              phase <= PH_IDLE;
            end else begin
              raw_count <= raw_count + RAW_W'(1);
              lrc       <= lrc ^ b;
              if (is_split) begin
                if (room) begin
                  fields_kept <= fields_kept + lrcdf_pkg::COUNT_W'(1);
                end
                cur_chars <= '0;
                cur_data  <= '0;
                if (b == lrcdf_pkg::ETX_BYTE) begin
                  phase <= PH_CHECK;
                end
              end else if (do_add) begin
                cur_data  <= cur_data_next;
                cur_chars <= cur_chars + lrcdf_pkg::LEN_W'(1);
              end
            end
          end
          PH_CHECK: begin
            phase <= PH_IDLE;
            // A good frame keeps the store busy until the burst has been read out.
            if (!to && b == lrc) begin
              hold <= 1'b1;
            end
          end
          default: begin
            phase <= PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_close && room) begin
      store_data[fields_kept[SIDX_W-1:0]] <= cur_data;
      store_len[fields_kept[SIDX_W-1:0]]  <= cur_chars;
    end
  end

  assign rd.data = lrcdf_pkg::DATA_W'(store_data[rd_idx[SIDX_W-1:0]]);
  assign rd.len  = store_len[rd_idx[SIDX_W-1:0]];

  a_burst_count: assert property (@(posedge clk) disable iff (rst)
      (push && push_cmd.kind == lrcdf_pkg::CMD_BURST) |->
      (push_cmd.count != '0 && push_cmd.count <= lrcdf_pkg::COUNT_W'(MAX_FIELDS)))
    else $error("burst command with an impossible field count");

  a_no_write_while_held: assert property (@(posedge clk) disable iff (rst)
      hold |-> !do_close)
    else $error("field store written while a burst is being read out");

  a_hold_set: assert property (@(posedge clk) disable iff (rst)
      (push && push_cmd.kind == lrcdf_pkg::CMD_BURST) |=> hold)
    else $error("burst issued without holding the front end");

endmodule

// ----- hw/rtl/lrcdf_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrcdf_queue
// Two-entry command queue between the frame parser and the sequencer.
// ---------------------------------------------------------------------------
module lrcdf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lrcdf_pkg::cmd_t  push_cmd,
  output logic             q_ready,
  input  logic             pop,
  output logic             q_valid,
  output lrcdf_pkg::cmd_t  pop_cmd
);

  lrcdf_pkg::cmd_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign q_ready = count != 2'd2;
  assign q_valid = count != 2'd0;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
      push |-> (q_ready || pop))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
      pop |-> q_valid)
    else $error("command queue underflow");

endmodule

// ----- hw/rtl/lrcdf_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lrcdf_back
// Result sequencer: turns queued commands into error results or a burst of
// one result per stored field, through a registered output stage.
// ---------------------------------------------------------------------------
module lrcdf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  lrcdf_pkg::cmd_t              pop_cmd,
  output logic                         pop,
  output logic [lrcdf_pkg::IDX_W-1:0]  rd_idx,
  input  lrcdf_pkg::field_rd_t         rd,
  output logic                         burst_done,
  lrcdf_out_if.source                  dout
);

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

  state_t                          state;
  logic [lrcdf_pkg::IDX_W-1:0]     idx;
  logic [lrcdf_pkg::COUNT_W-1:0]   total;
  logic                            slot_free;
  logic                            last_field;

  assign slot_free  = !dout.valid || dout.ready;
  assign pop        = (state == S_IDLE) && q_valid && slot_free;
  assign rd_idx     = (state == S_IDLE) ? '0 : idx;
  assign last_field = (state == S_IDLE)
      ? (pop_cmd.count == lrcdf_pkg::COUNT_W'(1))
      : (lrcdf_pkg::COUNT_W'(idx) + lrcdf_pkg::COUNT_W'(1) == total);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      dout.valid  <= 1'b0;
      burst_done  <= 1'b0;
      idx         <= '0;
      total       <= '0;
    end else begin
      burst_done <= 1'b0;
      if (slot_free) begin
        dout.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            dout.valid <= 1'b1;
            if (pop_cmd.kind == lrcdf_pkg::CMD_ERROR) begin
              dout.status       <= pop_cmd.status;
              dout.field_index  <= '0;
              dout.field_length <= '0;
              dout.field_data   <= '0;
              dout.is_last      <= 1'b1;
            end else begin
              dout.status       <= lrcdf_pkg::ST_OK;
              dout.field_index  <= '0;
              dout.field_length <= rd.len;
              dout.field_data   <= rd.data;
              dout.is_last      <= last_field;
              total             <= pop_cmd.count;
              idx               <= lrcdf_pkg::IDX_W'(1);
              if (last_field) begin
                burst_done <= 1'b1;
              end else begin
                state <= S_BURST;
              end
            end
          end
        end
        S_BURST: begin
          if (slot_free) begin
            dout.valid        <= 1'b1;
            dout.status       <= lrcdf_pkg::ST_OK;
            dout.field_index  <= idx;
            dout.field_length <= rd.len;
            dout.field_data   <= rd.data;
            dout.is_last      <= last_field;
            idx               <= idx + lrcdf_pkg::IDX_W'(1);
            if (last_field) begin
              burst_done <= 1'b1;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
      (dout.valid && dout.status != lrcdf_pkg::ST_OK) |->
      (dout.is_last && dout.field_index == '0 && dout.field_length == '0))
    else $error("error result carries field content");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
      burst_done |-> (dout.valid && dout.is_last && dout.status == lrcdf_pkg::ST_OK))
    else $error("burst finished without a last result");

  a_burst_in_range: assert property (@(posedge clk) disable iff (rst)
      (state == S_BURST) |-> (lrcdf_pkg::COUNT_W'(idx) < total))
    else $error("burst index ran past the field count");

endmodule

// ----- hw/rtl/stx_etx_lrc_field_deframer_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stx_etx_lrc_field_deframer_core
// STX/ETX frame receiver with XOR LRC check and '|' field splitting.
// ---------------------------------------------------------------------------
// Each received byte (or timeout event) is taken while the parser is not held
// and the command queue has room. An error gives a single status result,
// passed through a two-entry command queue into the output register. A frame
// whose LRC byte matches gives one result per kept field, one per cycle out of
// the field store while the result sink keeps up; the parser takes no new byte
// from the LRC byte until the last of those results sits in the output
// register, so an accepted frame holds input through the whole burst,
// including any stalls of the result sink.
module stx_etx_lrc_field_deframer_core #(
  parameter int unsigned MAX_FIELDS       = 8,
  parameter int unsigned FIELD_SLOT_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  lrcdf_in_if.sink      din,
  lrcdf_out_if.source   dout
);

  logic                         q_ready;
  logic                         push;
  lrcdf_pkg::cmd_t              push_cmd;
  logic                         q_valid;
  logic                         pop;
  lrcdf_pkg::cmd_t              pop_cmd;
  logic                         burst_done;
  logic [lrcdf_pkg::IDX_W-1:0]  rd_idx;
  lrcdf_pkg::field_rd_t         rd;

  lrcdf_front #(
    .MAX_FIELDS       (MAX_FIELDS),
    .FIELD_SLOT_BYTES (FIELD_SLOT_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .q_ready    (q_ready),
    .push       (push),
    .push_cmd   (push_cmd),
    .burst_done (burst_done),
    .rd_idx     (rd_idx),
    .rd         (rd)
  );

  lrcdf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_cmd  (pop_cmd)
  );

  lrcdf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop),
    .rd_idx     (rd_idx),
    .rd         (rd),
    .burst_done (burst_done),
    .dout       (dout)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the STX/ETX LRC field deframer core.
// ---------------------------------------------------------------------------
// Received bytes and timeout events are queued up front. They start with a
// short directed list and continue with random frames: good ones, bad LRC,
// timeouts, overruns and idle noise. A clocked driver feeds them through the
// input channel. A clocked monitor runs every accepted request through a
// local deframer predictor and checks each delivered result, in order,
// against the oldest predicted one. Both sides idle at random in three
// phases, the last with no idling at all.
module tb_top;

  localparam int unsigned N_FIELDS   = 8;
  localparam int unsigned SLOT_BYTES = 8;
  localparam int unsigned KEEP_BYTES = SLOT_BYTES - 1;
  localparam int unsigned RAW_LIMIT  = N_FIELDS * SLOT_BYTES + 2;
  localparam int unsigned ITEM_GOAL  = 310;

  typedef struct {
    logic [7:0] rx_byte;
    logic       timeout;
  } rx_item_t;

  typedef struct packed {
    logic [lrcdf_pkg::STAT_W-1:0] status;
    logic [lrcdf_pkg::IDX_W-1:0]  field_index;
    logic [lrcdf_pkg::LEN_W-1:0]  field_length;
    logic [lrcdf_pkg::DATA_W-1:0] field_data;
    logic                         is_last;
  } field_result_t;

  typedef enum logic [1:0] {
    HUNT_STX,
    IN_BODY,
    WAIT_LRC
  } rx_phase_t;

  typedef enum {
    TAIL_LRC_OK,
    TAIL_LRC_WRONG,
    TAIL_LRC_TIMEOUT,
    TAIL_BODY_TIMEOUT,
    TAIL_OVERRUN
  } frame_tail_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lrcdf_in_if  din_if ();
  lrcdf_out_if dout_if ();

  stx_etx_lrc_field_deframer_core #(
    .MAX_FIELDS       (N_FIELDS),
    .FIELD_SLOT_BYTES (SLOT_BYTES)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_item_t      rx_queue[$];
  logic [7:0]    body_q[$];
  field_result_t expected_fields[$];

  int unsigned items_total = 0;
  int unsigned items_sent  = 0;
  int unsigned items_taken = 0;
  int unsigned mismatches  = 0;
  int unsigned frames_ok   = 0;
  int unsigned fields_ok   = 0;
  int unsigned errors_seen = 0;
  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;

  // Predictor state.
  rx_phase_t                    ph = HUNT_STX;
  logic [7:0]                   lrc_acc = '0;
  logic [6:0]                   raw_cnt = '0;
  logic [3:0]                   kept = '0;
  logic [2:0]                   cur_chars = '0;
  logic [lrcdf_pkg::DATA_W-1:0] slot_data [N_FIELDS];
  logic [lrcdf_pkg::LEN_W-1:0]  slot_len [N_FIELDS];

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void expect_status(input logic [lrcdf_pkg::STAT_W-1:0] code);
    field_result_t r;
    r.status       = code;
    r.field_index  = '0;
    r.field_length = '0;
    r.field_data   = '0;
    r.is_last      = 1'b1;
    expected_fields.push_back(r);
    errors_seen++;
    ph = HUNT_STX;
  endfunction

  function automatic void close_field();
    if (kept < N_FIELDS) begin
      slot_len[kept[2:0]] = cur_chars;
      kept++;
      if (kept < N_FIELDS) begin
        slot_data[kept[2:0]] = '0;
      end
    end
    cur_chars = '0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic to);
    field_result_t r;
    case (ph)
      HUNT_STX: begin
        if (to) begin
          expect_status(lrcdf_pkg::ST_IDLE_TO);
        end else if (b != lrcdf_pkg::STX_BYTE) begin
          expect_status(lrcdf_pkg::ST_NOT_STX);
        end else begin
          ph           = IN_BODY;
          lrc_acc      = '0;
          raw_cnt      = '0;
          kept         = '0;
          cur_chars    = '0;
          slot_data[0] = '0;
        end
      end
      IN_BODY: begin
        // A timeout wins over the length limit.
        if (to) begin
          expect_status(lrcdf_pkg::ST_BODY_TO);
        end else if (raw_cnt >= RAW_LIMIT) begin
          expect_status(lrcdf_pkg::ST_TOO_LONG);
        end else begin
          raw_cnt++;
          lrc_acc ^= b;
          if (b == lrcdf_pkg::ETX_BYTE) begin
            close_field();
            ph = WAIT_LRC;
          end else if (b == lrcdf_pkg::SEP_BYTE) begin
            close_field();
          end else if (kept < N_FIELDS && cur_chars < KEEP_BYTES) begin
            slot_data[kept[2:0]][8*cur_chars +: 8] = b;
            cur_chars++;
          end
        end
      end
      default: begin
        if (to) begin
          expect_status(lrcdf_pkg::ST_LRC_TO);
        end else if (b != lrc_acc) begin
          expect_status(lrcdf_pkg::ST_LRC_BAD);
        end else begin
          ph = HUNT_STX;
          frames_ok++;
          for (int k = 0; k < kept; k++) begin
            r.status       = lrcdf_pkg::ST_OK;
            r.field_index  = k[lrcdf_pkg::IDX_W-1:0];
            r.field_length = slot_len[k];
            r.field_data   = slot_data[k];
            r.is_last      = (k + 1 == kept);
            expected_fields.push_back(r);
            fields_ok++;
          end
        end
      end
    endcase
  endfunction

  function automatic void push_item(input logic [7:0] b, input logic to);
    rx_item_t it;
    it.rx_byte = b;
    it.timeout = to;
    rx_queue.push_back(it);
  endfunction

  // Any byte except the end and separator bytes.
  function automatic logic [7:0] body_char();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == lrcdf_pkg::ETX_BYTE || b == lrcdf_pkg::SEP_BYTE) begin
      b ^= 8'h80;
    end
    return b;
  endfunction

  function automatic void random_body();
    int unsigned nf;
    int unsigned len;
    body_q.delete();
    nf = ($urandom_range(3) == 0) ? $urandom_range(1, 10) : $urandom_range(1, 4);
    for (int unsigned f = 0; f < nf; f++) begin
      if (f > 0) begin
        body_q.push_back(lrcdf_pkg::SEP_BYTE);
      end
      len = ($urandom_range(3) == 0) ? $urandom_range(6, 9) : $urandom_range(0, 4);
      for (int unsigned i = 0; i < len; i++) begin
        body_q.push_back(body_char());
      end
    end
  endfunction

  // Body of n bytes with separators sprinkled in, used for near-limit frames.
  function automatic void long_body(input int unsigned n);
    body_q.delete();
    for (int unsigned i = 0; i < n; i++) begin
      body_q.push_back(($urandom_range(99) < 15) ? lrcdf_pkg::SEP_BYTE : body_char());
    end
  endfunction

  function automatic void emit_frame(input frame_tail_t tail);
    logic [7:0] lrc;
    lrc = '0;
    push_item(lrcdf_pkg::STX_BYTE, 1'b0);
    foreach (body_q[i]) begin
      push_item(body_q[i], 1'b0);
      lrc ^= body_q[i];
    end
    case (tail)
      TAIL_BODY_TIMEOUT: push_item(8'($urandom_range(255)), 1'b1);
      TAIL_OVERRUN: begin
        if ($urandom_range(1) == 0) begin
          push_item(body_char(), 1'b0);
        end else begin
          push_item(8'($urandom_range(255)), 1'b1);
        end
      end
      default: begin
        push_item(lrcdf_pkg::ETX_BYTE, 1'b0);
        lrc ^= lrcdf_pkg::ETX_BYTE;
        if (tail == TAIL_LRC_OK) begin
          push_item(lrc, 1'b0);
        end else if (tail == TAIL_LRC_WRONG) begin
          push_item(lrc ^ 8'($urandom_range(1, 255)), 1'b0);
        end else begin
          push_item(8'($urandom_range(255)), 1'b1);
        end
      end
    endcase
  endfunction

  always_comb begin
    if (items_sent < items_total / 3) begin
      send_idle_pct  = 21;
      sink_stall_pct = 64;
    end else if (items_sent < 2 * items_total / 3) begin
      send_idle_pct  = 64;
      sink_stall_pct = 21;
    end else begin
      send_idle_pct  = 0;
      sink_stall_pct = 0;
    end
  end

  // Driver: a new request goes out once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (!din_if.valid || din_if.ready) begin
      if (rx_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        din_if.valid   <= 1'b1;
        din_if.rx_byte <= rx_queue[0].rx_byte;
        din_if.timeout <= rx_queue[0].timeout;
        rx_queue.delete(0);
        items_sent++;
      end else begin
        din_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: predict from accepted requests first, then check results.
  always @(posedge clk) begin : monitor
    field_result_t got;
    field_result_t want;
    if (!rst) begin
      if (din_if.valid && din_if.ready) begin
        deframe_byte(din_if.rx_byte, din_if.timeout);
        items_taken++;
      end
      if (dout_if.valid && dout_if.ready) begin
        got.status       = dout_if.status;
        got.field_index  = dout_if.field_index;
        got.field_length = dout_if.field_length;
        got.field_data   = dout_if.field_data;
        got.is_last      = dout_if.is_last;
        if (expected_fields.size() == 0) begin
          flag_mismatch($sformatf("unexpected result st=%0d idx=%0d len=%0d data=%h last=%0b",
                                  got.status, got.field_index, got.field_length,
                                  got.field_data, got.is_last));
        end else begin
          want = expected_fields.pop_front();
          if (got !== want) begin
            flag_mismatch({
              $sformatf("got st=%0d idx=%0d len=%0d data=%h last=%0b",
                        got.status, got.field_index, got.field_length,
                        got.field_data, got.is_last),
              $sformatf(", want st=%0d idx=%0d len=%0d data=%h last=%0b",
                        want.status, want.field_index, want.field_length,
                        want.field_data, want.is_last)});
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned goal;
    int unsigned pick;
    int unsigned cut;

    // Directed: errors in idle, empty body, zero and start bytes inside a
    // field, and each timeout and bad check byte.
    push_item(8'hA5, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    body_q.delete();
    emit_frame(TAIL_LRC_OK);
    body_q = {8'h41, 8'h00, lrcdf_pkg::STX_BYTE, lrcdf_pkg::SEP_BYTE, 8'h42};
    emit_frame(TAIL_LRC_OK);
    body_q = {8'h41};
    emit_frame(TAIL_BODY_TIMEOUT);
    body_q.delete();
    emit_frame(TAIL_LRC_TIMEOUT);
    body_q.delete();
    emit_frame(TAIL_LRC_WRONG);

    goal = ITEM_GOAL;
    // Open the random part with an overrun and a frame at the length limit.
    long_body(RAW_LIMIT);
    emit_frame(TAIL_OVERRUN);
    long_body(RAW_LIMIT - 1);
    emit_frame(TAIL_LRC_OK);
    while (rx_queue.size() < goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        random_body();
        emit_frame(TAIL_LRC_OK);
      end else if (pick < 63) begin
        random_body();
        emit_frame(TAIL_LRC_WRONG);
      end else if (pick < 69) begin
        random_body();
        emit_frame(TAIL_LRC_TIMEOUT);
      end else if (pick < 76) begin
        random_body();
        cut = $urandom_range(body_q.size());
        while (body_q.size() > cut) begin
          void'(body_q.pop_back());
        end
        emit_frame(TAIL_BODY_TIMEOUT);
      end else if (pick < 81) begin
        long_body($urandom_range(RAW_LIMIT - 2, RAW_LIMIT));
        emit_frame(($urandom_range(1) == 0) ? TAIL_OVERRUN : TAIL_LRC_OK);
      end else begin
        for (int unsigned i = $urandom_range(1, 3); i > 0; i--) begin
          push_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
      end
    end
    items_total = rx_queue.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != items_total) @(negedge clk);
    while (expected_fields.size() != 0) @(negedge clk);
    // Room for any stray result from the last requests.
    repeat (40) @(negedge clk);

    $display("Fed %0d bytes and timeouts: %0d frames accepted with %0d field results,",
             items_taken, frames_ok, fields_ok);
    $display("%0d error statuses; idling ran sender-heavy, receiver-heavy and with none.",
             errors_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d requests taken, %0d results outstanding.",
             items_taken, items_total, expected_fields.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
